/* hw/rtl/rgb_led_pattern_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer assertion macros
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PATTERN_SEQUENCER_MACROS_SVH
`define RGB_LED_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define RLPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlps assertion failed");
// Next-cycle implication, disabled while in reset
`define RLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlps assertion failed");
`else
`define RLPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/rlps_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer package
// Widths, pattern table and the sequencer state type.
// ----------------------------------------------------------------------------
package rlps_pkg;

    localparam int LEVEL_MAX = 255;
    localparam int LEVEL_W   = $clog2(LEVEL_MAX + 1);
    localparam int DUTY_W    = 8;
    localparam int FULL_ON   = 255;
    localparam int NUM_CH    = 6;
    localparam int NUM_SEG   = 12;
    localparam int SEG_W     = $clog2(NUM_SEG);
    localparam int HOLD_W    = 17;
    localparam int DWELL_W   = 10;
    localparam int MODE_W    = 3;
    localparam int LVL_EXT_W = (LEVEL_W > DUTY_W) ? LEVEL_W : DUTY_W;

    // Channel bits
    localparam logic [NUM_CH-1:0] CH_RA = 6'h01;
    localparam logic [NUM_CH-1:0] CH_RB = 6'h02;
    localparam logic [NUM_CH-1:0] CH_GA = 6'h04;
    localparam logic [NUM_CH-1:0] CH_GB = 6'h08;
    localparam logic [NUM_CH-1:0] CH_BA = 6'h10;
    localparam logic [NUM_CH-1:0] CH_BB = 6'h20;
    localparam logic [NUM_CH-1:0] CH_NONE = 6'h00;

    typedef enum logic [MODE_W-1:0] {
        MODE_FADE  = 3'd0,
        MODE_CHASE = 3'd1,
        MODE_PULSE = 3'd2,
        MODE_WHITE = 3'd3,
        MODE_SIREN = 3'd4
    } mode_t;

    localparam logic REG_PATTERN_MODE = 1'b0;
    localparam logic REG_DWELL_MS     = 1'b1;

    typedef enum logic [2:0] {
        WAIT_NONE = 3'd0,
        WAIT_D1   = 3'd1,
        WAIT_D2   = 3'd2,
        WAIT_D10  = 3'd3,
        WAIT_D100 = 3'd4,
        WAIT_F20  = 3'd5,
        WAIT_F200 = 3'd6
    } wait_t;

    typedef struct packed {
        logic              is_ramp;
        logic [NUM_CH-1:0] chans;
        logic              up;
        wait_t             wait_code;
        logic [NUM_CH-1:0] pre_mask;
        logic [NUM_CH-1:0] pre_on;
    } seg_t;

    typedef struct packed {
        logic [SEG_W-1:0]                seg;
        logic [LEVEL_W-1:0]              level;
        logic [HOLD_W-1:0]               hold;
        logic [NUM_CH-1:0][DUTY_W-1:0]   duty;
    } seq_state_t;

    function automatic seg_t rmp(input logic [NUM_CH-1:0] c, input logic u,
                                 input logic [NUM_CH-1:0] pm,
                                 input logic [NUM_CH-1:0] pv);
        seg_t s;
        s.is_ramp   = 1'b1;
        s.chans     = c;
        s.up        = u;
        s.wait_code = WAIT_NONE;
        s.pre_mask  = pm;
        s.pre_on    = pv;
        return s;
    endfunction

    function automatic seg_t wt(input wait_t w, input logic [NUM_CH-1:0] pm,
                                input logic [NUM_CH-1:0] pv);
        seg_t s;
        s.is_ramp   = 1'b0;
        s.chans     = CH_NONE;
        s.up        = 1'b0;
        s.wait_code = w;
        s.pre_mask  = pm;
        s.pre_on    = pv;
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] pat_len(input logic [MODE_W-1:0] mode);
        logic [SEG_W-1:0] n;
        case (mode)
            MODE_FADE:  n = SEG_W'(11);
            MODE_CHASE: n = SEG_W'(3);
            MODE_PULSE: n = SEG_W'(12);
            MODE_WHITE: n = SEG_W'(6);
            MODE_SIREN: n = SEG_W'(7);
            default:    n = SEG_W'(1);
        endcase
        return n;
    endfunction

    function automatic seg_t seg_lookup(input logic [MODE_W-1:0] mode,
                                        input logic [SEG_W-1:0] idx);
        seg_t s;
        s = wt(WAIT_NONE, CH_NONE, CH_NONE);
        case (mode)
            MODE_FADE:
                case (idx)
                    0:       s = rmp(CH_RA | CH_BB, 1'b1, CH_NONE, CH_NONE);
                    2:       s = rmp(CH_BA | CH_GB, 1'b0, CH_NONE, CH_NONE);
                    4:       s = rmp(CH_GA | CH_RB, 1'b1, CH_NONE, CH_NONE);
                    6:       s = rmp(CH_RA | CH_BB, 1'b0, CH_NONE, CH_NONE);
                    8:       s = rmp(CH_BA | CH_GB, 1'b1, CH_NONE, CH_NONE);
                    10:      s = rmp(CH_GA | CH_RB, 1'b0, CH_NONE, CH_NONE);
                    default: s = wt(WAIT_D1, CH_NONE, CH_NONE);
                endcase
            MODE_CHASE:
                case (idx)
                    0:       s = wt(WAIT_D100, CH_BA | CH_RA, CH_RA);
                    1:       s = wt(WAIT_D100, CH_RA | CH_GA, CH_GA);
                    default: s = wt(WAIT_D100, CH_BA | CH_GA, CH_BA);
                endcase
            MODE_PULSE:
                case (idx)
                    0:       s = rmp(CH_RA, 1'b1, CH_BA | CH_GA, CH_NONE);
                    2:       s = rmp(CH_RA, 1'b0, CH_NONE, CH_NONE);
                    4:       s = rmp(CH_GA, 1'b1, CH_NONE, CH_NONE);
                    6:       s = rmp(CH_GA, 1'b0, CH_NONE, CH_NONE);
                    8:       s = rmp(CH_BA, 1'b1, CH_NONE, CH_NONE);
                    10:      s = rmp(CH_BA, 1'b0, CH_NONE, CH_NONE);
                    default: s = wt(WAIT_D2, CH_NONE, CH_NONE);
                endcase
            MODE_WHITE:
                case (idx)
                    0:       s = rmp(CH_GA, 1'b1, CH_RA | CH_GA | CH_BA, CH_RA);
                    1:       s = rmp(CH_BA, 1'b1, CH_NONE, CH_NONE);
                    3:       s = rmp(CH_GA, 1'b0, CH_NONE, CH_NONE);
                    4:       s = rmp(CH_BA, 1'b0, CH_NONE, CH_NONE);
                    default: s = wt(WAIT_D10, CH_NONE, CH_NONE);
                endcase
            MODE_SIREN:
                case (idx)
                    0:       s = wt(WAIT_F200, CH_RA, CH_RA);
                    1:       s = wt(WAIT_F200, CH_RA, CH_NONE);
                    2:       s = wt(WAIT_F200, CH_BA, CH_BA);
                    3:       s = wt(WAIT_F20, CH_BA, CH_NONE);
                    4:       s = wt(WAIT_F20, CH_RA, CH_RA);
                    5:       s = wt(WAIT_F20, CH_RA | CH_BA, CH_BA);
                    default: s = wt(WAIT_F200, CH_BA, CH_NONE);
                endcase
            default: s = wt(WAIT_NONE, CH_NONE, CH_NONE);
        endcase
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] start_level(input seg_t s);
        return (s.is_ramp && !s.up) ? LEVEL_W'(LEVEL_MAX) : '0;
    endfunction

endpackage

/* hw/rtl/rgb_led_pattern_sequencer.sv */
// Latency: a result is valid in the cycle after its tick beat is accepted.
// Throughput: one tick beat per clock; the sequencer state and the result
// register both update on the accepting edge.
// A stalled result holds the input side until the result beat is taken.
// Reset clears the sequencer state and duties, sets pattern_mode to 0 and
// dwell_ms to 10, and empties the result register.
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer
// Steps one of five light patterns per millisecond tick and reports the six
// PWM duties and a pass-end flag after every tick.
// ----------------------------------------------------------------------------
`include "rgb_led_pattern_sequencer_macros.svh"

module rgb_led_pattern_sequencer
    import rlps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [DWELL_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DUTY_W-1:0]  red_a_duty,
    output logic [DUTY_W-1:0]  red_b_duty,
    output logic [DUTY_W-1:0]  green_a_duty,
    output logic [DUTY_W-1:0]  green_b_duty,
    output logic [DUTY_W-1:0]  blue_a_duty,
    output logic [DUTY_W-1:0]  blue_b_duty,
    output logic               pass_end
);

    logic [MODE_W-1:0]             mode_reg;
    logic [DWELL_W-1:0]            dwell_reg;
    seq_state_t                    state_reg;
    seq_state_t                    state_next;
    logic                          pass_end_next;
    logic                          out_valid_reg;
    logic [NUM_CH-1:0][DUTY_W-1:0] duty_out_reg;
    logic                          pass_end_reg;
    logic                          in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FADE;
            dwell_reg <= DWELL_W'(10);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                REG_DWELL_MS:     dwell_reg <= cfg_data;
                default:          dwell_reg <= dwell_reg;
            endcase
        end
    end

    rlps_step u_step (
        .mode     (mode_reg),
        .dwell    (dwell_reg),
        .restart  (restart),
        .cur      (state_reg),
        .nxt      (state_next),
        .pass_end (pass_end_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            // Load on a new beat; drop once the pending result is taken
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            duty_out_reg <= state_next.duty;
            pass_end_reg <= pass_end_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_a_duty   = duty_out_reg[0];
    assign red_b_duty   = duty_out_reg[1];
    assign green_a_duty = duty_out_reg[2];
    assign green_b_duty = duty_out_reg[3];
    assign blue_a_duty  = duty_out_reg[4];
    assign blue_b_duty  = duty_out_reg[5];
    assign pass_end     = pass_end_reg;

    `RLPS_ASSERT_NEXT(a_fire_loads_result, clk, rst_n, in_fire, out_valid_reg)
    `RLPS_ASSERT_IMPLY(a_pass_end_at_start, clk, rst_n, out_valid_reg && pass_end_reg, (state_reg.seg == '0) && (state_reg.hold == '0))
    `RLPS_ASSERT_IMPLY(a_seg_in_table, clk, rst_n, 1'b1, state_reg.seg < SEG_W'(NUM_SEG))
    `RLPS_ASSERT_NEXT(a_idle_mode_freezes, clk, rst_n, in_fire && (mode_reg > MODE_SIREN), !pass_end_reg && $stable(state_reg))

endmodule

/* hw/rtl/rlps_step.sv */
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer tick step
// Next sequencer state and pass-end flag for one tick.
// ----------------------------------------------------------------------------
module rlps_step
    import rlps_pkg::*;
(
    input  logic [MODE_W-1:0]  mode,
    input  logic [DWELL_W-1:0] dwell,
    input  logic               restart,
    input  seq_state_t         cur,
    output seq_state_t         nxt,
    output logic               pass_end
);

    logic [SEG_W-1:0]     len;
    logic [DWELL_W-1:0]   d;
    logic [HOLD_W-1:0]    d_ext;
    logic                 seg_restart;
    logic [SEG_W-1:0]     seg0;
    logic [HOLD_W-1:0]    hold0;
    logic [HOLD_W-1:0]    hold1;
    logic [LEVEL_W-1:0]   lvl0;
    seg_t                 s;
    seg_t                 s_adv;
    logic [HOLD_W-1:0]    unit;
    logic [LVL_EXT_W-1:0] lvl_ext;
    logic [DUTY_W-1:0]    lvl_duty;
    logic [SEG_W:0]       seg_inc;
    logic [SEG_W-1:0]     seg_adv;
    logic                 wrap;

    assign len   = pat_len(mode);
    assign d     = (dwell == '0) ? DWELL_W'(1) : dwell;
    assign d_ext = HOLD_W'(d);

    assign seg_restart = restart || (cur.seg >= len);
    assign seg0  = seg_restart ? '0 : cur.seg;
    assign hold0 = seg_restart ? '0 : cur.hold;
    assign lvl0  = seg_restart ? start_level(seg_lookup(mode, '0)) : cur.level;
    assign s     = seg_lookup(mode, seg0);

    assign hold1 = (hold0 == {HOLD_W{1'b1}}) ? hold0 : hold0 + HOLD_W'(1);

    // Clamp the ramp level onto the duty range
    assign lvl_ext  = LVL_EXT_W'(lvl0);
    assign lvl_duty = (lvl_ext > LVL_EXT_W'(FULL_ON)) ? DUTY_W'(FULL_ON)
                                                      : lvl_ext[DUTY_W-1:0];

    always_comb
    begin
        case (s.wait_code)
            WAIT_D2:   unit = d_ext << 1;
            WAIT_D10:  unit = (d_ext << 3) + (d_ext << 1);
            WAIT_D100: unit = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
            WAIT_F20:  unit = HOLD_W'(20);
            WAIT_F200: unit = HOLD_W'(200);
            default:   unit = d_ext;
        endcase
        if (s.is_ramp)
        begin
            unit = d_ext;
        end
    end

    assign seg_inc = {1'b0, seg0} + (SEG_W + 1)'(1);
    assign wrap    = seg_inc >= {1'b0, len};
    assign seg_adv = wrap ? '0 : seg_inc[SEG_W-1:0];
    assign s_adv   = seg_lookup(mode, seg_adv);

    always_comb
    begin
        nxt      = cur;
        pass_end = 1'b0;
        if (mode <= MODE_SIREN)
        begin
            nxt.seg   = seg0;
            nxt.level = lvl0;
            nxt.hold  = hold1;
            if (hold0 == '0)
            begin
                if (!s.is_ramp || lvl0 == start_level(s))
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (s.pre_mask[i])
                        begin
                            nxt.duty[i] = s.pre_on[i] ? DUTY_W'(FULL_ON) : '0;
                        end
                    end
                end
                if (s.is_ramp)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (s.chans[i])
                        begin
                            nxt.duty[i] = lvl_duty;
                        end
                    end
                end
            end
            if (hold1 >= unit)
            begin
                nxt.hold = '0;
                if (s.is_ramp && s.up && lvl0 < LEVEL_W'(LEVEL_MAX))
                begin
                    nxt.level = lvl0 + LEVEL_W'(1);
                end
                else if (s.is_ramp && !s.up && lvl0 != '0)
                begin
                    nxt.level = lvl0 - LEVEL_W'(1);
                end
                else
                begin
                    pass_end  = wrap;
                    nxt.seg   = seg_adv;
                    nxt.level = start_level(s_adv);
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer testbench
// Drives millisecond ticks and register writes with random idling on both
// sides and checks every duty beat against a cycle-free pattern predictor or a directed golden beat.
// ----------------------------------------------------------------------------
module tb_top
    import rlps_pkg::*;
();

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 40;
    localparam int FADE_TICKS      = 259;
    localparam int HOLD_SAT        = (1 << HOLD_W) - 1;
    localparam int DIR_ROWS        = 28;

    localparam logic [MODE_W-1:0] MODE_RSV5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSV6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSV7 = 3'd7;

    typedef struct packed {
        logic                            pass_end;
        logic [NUM_CH-1:0][DUTY_W-1:0]   duty;
    } led_beat_t;

    typedef struct packed {
        logic              ramp;
        logic [NUM_CH-1:0] chans;
        logic              rising;
        wait_t             wcode;
        logic [NUM_CH-1:0] pre_mask;
        logic [NUM_CH-1:0] pre_on;
    } pat_seg_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               arg;       // restart for a tick, register index for a write
        logic [DWELL_W-1:0] data;
        logic               has_gold;
        led_beat_t          gold;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [DWELL_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DUTY_W-1:0]  red_a_duty;
    logic [DUTY_W-1:0]  red_b_duty;
    logic [DUTY_W-1:0]  green_a_duty;
    logic [DUTY_W-1:0]  green_b_duty;
    logic [DUTY_W-1:0]  blue_a_duty;
    logic [DUTY_W-1:0]  blue_b_duty;
    logic               pass_end;

    // Predictor state and register copies
    pat_seg_t                      seg_tab [5][NUM_SEG];
    int unsigned                   seg_total [5];
    logic [MODE_W-1:0]             mode_q;
    logic [DWELL_W-1:0]            dwell_q;
    int unsigned                   cur_seg;
    int unsigned                   cur_level;
    int unsigned                   cur_hold;
    logic [NUM_CH-1:0][DUTY_W-1:0] cur_duty;

    led_beat_t pending_duties [$];
    dir_row_t  dir_rows [DIR_ROWS];
    string     chan_name [NUM_CH] = '{"red_a_duty", "red_b_duty", "green_a_duty",
                                      "green_b_duty", "blue_a_duty", "blue_b_duty"};

    logic      any_fail = 1'b0;
    int        report_cnt = 0;
    int        cycle_cnt = 0;
    logic      in_lazy = 1'b0;
    logic      out_lazy = 1'b0;
    logic      hold_off_req = 1'b0;
    int        stall_left = 0;
    int        ci;
    led_beat_t got_beat;
    led_beat_t want_beat;

    rgb_led_pattern_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_a_duty   (red_a_duty),
        .red_b_duty   (red_b_duty),
        .green_a_duty (green_a_duty),
        .green_b_duty (green_b_duty),
        .blue_a_duty  (blue_a_duty),
        .blue_b_duty  (blue_b_duty),
        .pass_end     (pass_end)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic pat_seg_t ramp_seg(input logic [NUM_CH-1:0] ch, input logic up,
                                          input logic [NUM_CH-1:0] pm,
                                          input logic [NUM_CH-1:0] pv);
        pat_seg_t s;
        s.ramp     = 1'b1;
        s.chans    = ch;
        s.rising   = up;
        s.wcode    = WAIT_NONE;
        s.pre_mask = pm;
        s.pre_on   = pv;
        return s;
    endfunction

    function automatic pat_seg_t hold_seg(input wait_t w, input logic [NUM_CH-1:0] pm,
                                          input logic [NUM_CH-1:0] pv);
        pat_seg_t s;
        s.ramp     = 1'b0;
        s.chans    = CH_NONE;
        s.rising   = 1'b0;
        s.wcode    = w;
        s.pre_mask = pm;
        s.pre_on   = pv;
        return s;
    endfunction

    function automatic led_beat_t duties_of(input int ra, input int rb, input int ga,
                                            input int gb, input int ba, input int bb,
                                            input logic pe);
        led_beat_t b;
        b.duty[0]  = DUTY_W'(ra);
        b.duty[1]  = DUTY_W'(rb);
        b.duty[2]  = DUTY_W'(ga);
        b.duty[3]  = DUTY_W'(gb);
        b.duty[4]  = DUTY_W'(ba);
        b.duty[5]  = DUTY_W'(bb);
        b.pass_end = pe;
        return b;
    endfunction

    function automatic int unsigned first_level(input pat_seg_t s);
        return (s.ramp && !s.rising) ? LEVEL_MAX : 0;
    endfunction

    // Advance the pattern by one tick and return the duties it leaves behind
    function automatic led_beat_t step_pattern(input logic rs);
        led_beat_t   b;
        pat_seg_t    s;
        int unsigned m;
        int unsigned seg_n;
        int unsigned dw;
        int unsigned span;
        int          i;
        b.pass_end = 1'b0;
        if (mode_q <= MODE_SIREN)
        begin
            m     = mode_q;
            seg_n = seg_total[m];
            dw    = (dwell_q == '0) ? 1 : dwell_q;
            if (rs || cur_seg >= seg_n)
            begin
                cur_seg   = 0;
                cur_hold  = 0;
                cur_level = first_level(seg_tab[m][0]);
            end
            s = seg_tab[m][cur_seg];
            if (cur_hold == 0)
            begin
                // Fixed writes only on the segment's first tick
                if (!s.ramp || cur_level == first_level(s))
                    for (i = 0; i < NUM_CH; i++)
                        if (s.pre_mask[i])
                            cur_duty[i] = s.pre_on[i] ? DUTY_W'(FULL_ON) : '0;
                if (s.ramp)
                    for (i = 0; i < NUM_CH; i++)
                        if (s.chans[i])
                            cur_duty[i] = (cur_level > FULL_ON) ? DUTY_W'(FULL_ON)
                                                                : DUTY_W'(cur_level);
            end
            if (cur_hold < HOLD_SAT)
                cur_hold++;
            if (s.ramp)
                span = dw;
            else
                case (s.wcode)
                    WAIT_D2:   span = 2 * dw;
                    WAIT_D10:  span = 10 * dw;
                    WAIT_D100: span = 100 * dw;
                    WAIT_F20:  span = 20;
                    WAIT_F200: span = 200;
                    default:   span = dw;
                endcase
            if (cur_hold >= span)
            begin
                cur_hold = 0;
                if (s.ramp && s.rising && cur_level < LEVEL_MAX)
                    cur_level++;
                else if (s.ramp && !s.rising && cur_level > 0)
                    cur_level--;
                else
                begin
                    if (cur_seg + 1 >= seg_n)
                    begin
                        b.pass_end = 1'b1;
                        cur_seg    = 0;
                    end
                    else
                        cur_seg++;
                    cur_level = first_level(seg_tab[m][cur_seg]);
                end
            end
        end
        b.duty = cur_duty;
        return b;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        any_fail = 1'b1;
        if (report_cnt < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", what, want, got);
        report_cnt++;
    endtask

    // Offer one tick beat; predict its duties on acceptance
    task automatic offer_tick(input logic rs, input logic use_gold, input led_beat_t gold);
        int        gap;
        led_beat_t b;
        gap = in_lazy ? idle_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        b = step_pattern(rs);
        pending_duties.push_back(use_gold ? gold : b);
    endtask

    // Drain all results, then write one register
    task automatic write_reg(input logic idx, input logic [DWELL_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_PATTERN_MODE)
            mode_q = val[MODE_W-1:0];
        else
            dwell_q = val;
    endtask

    // Result side: check each beat, idle at random, hold off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_beat.duty     = {blue_b_duty, blue_a_duty, green_b_duty, green_a_duty,
                                     red_b_duty, red_a_duty};
                got_beat.pass_end = pass_end;
                if (pending_duties.size() == 0)
                    note_mismatch("unexpected result beat", 0, 1);
                else
                begin
                    want_beat = pending_duties.pop_front();
                    for (ci = 0; ci < NUM_CH; ci++)
                        if (got_beat.duty[ci] !== want_beat.duty[ci])
                            note_mismatch(chan_name[ci], want_beat.duty[ci], got_beat.duty[ci]);
                    if (got_beat.pass_end !== want_beat.pass_end)
                        note_mismatch("pass_end", want_beat.pass_end, got_beat.pass_end);
                end
            end
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (stall_left == 0 && out_lazy)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int                 k;
        int                 n;
        int                 ph;
        int                 r;
        logic [MODE_W-1:0]  mode_pick;
        logic [DWELL_W-1:0] dw_pick;
        logic [NUM_CH-1:0]  fade_ch [3];
        logic [NUM_CH-1:0]  pulse_ch [3];

        // Pattern table
        fade_ch  = '{CH_RA | CH_BB, CH_BA | CH_GB, CH_GA | CH_RB};
        pulse_ch = '{CH_RA, CH_GA, CH_BA};
        seg_total = '{11, 3, 12, 6, 7};
        for (k = 0; k < 11; k++)
            if (k % 2 == 0)
                seg_tab[MODE_FADE][k] = ramp_seg(fade_ch[(k / 2) % 3], (k / 2) % 2 == 0,
                                                 CH_NONE, CH_NONE);
            else
                seg_tab[MODE_FADE][k] = hold_seg(WAIT_D1, CH_NONE, CH_NONE);
        seg_tab[MODE_CHASE][0] = hold_seg(WAIT_D100, CH_BA | CH_RA, CH_RA);
        seg_tab[MODE_CHASE][1] = hold_seg(WAIT_D100, CH_RA | CH_GA, CH_GA);
        seg_tab[MODE_CHASE][2] = hold_seg(WAIT_D100, CH_BA | CH_GA, CH_BA);
        for (k = 0; k < 12; k++)
            if (k % 2 == 0)
                seg_tab[MODE_PULSE][k] = ramp_seg(pulse_ch[k / 4], (k / 2) % 2 == 0,
                                                  (k == 0) ? (CH_BA | CH_GA) : CH_NONE,
                                                  CH_NONE);
            else
                seg_tab[MODE_PULSE][k] = hold_seg(WAIT_D2, CH_NONE, CH_NONE);
        seg_tab[MODE_WHITE][0] = ramp_seg(CH_GA, 1'b1, CH_RA | CH_GA | CH_BA, CH_RA);
        seg_tab[MODE_WHITE][1] = ramp_seg(CH_BA, 1'b1, CH_NONE, CH_NONE);
        seg_tab[MODE_WHITE][2] = hold_seg(WAIT_D10, CH_NONE, CH_NONE);
        seg_tab[MODE_WHITE][3] = ramp_seg(CH_GA, 1'b0, CH_NONE, CH_NONE);
        seg_tab[MODE_WHITE][4] = ramp_seg(CH_BA, 1'b0, CH_NONE, CH_NONE);
        seg_tab[MODE_WHITE][5] = hold_seg(WAIT_D10, CH_NONE, CH_NONE);
        seg_tab[MODE_SIREN][0] = hold_seg(WAIT_F200, CH_RA, CH_RA);
        seg_tab[MODE_SIREN][1] = hold_seg(WAIT_F200, CH_RA, CH_NONE);
        seg_tab[MODE_SIREN][2] = hold_seg(WAIT_F200, CH_BA, CH_BA);
        seg_tab[MODE_SIREN][3] = hold_seg(WAIT_F20, CH_BA, CH_NONE);
        seg_tab[MODE_SIREN][4] = hold_seg(WAIT_F20, CH_RA, CH_RA);
        seg_tab[MODE_SIREN][5] = hold_seg(WAIT_F20, CH_RA | CH_BA, CH_BA);
        seg_tab[MODE_SIREN][6] = hold_seg(WAIT_F200, CH_BA, CH_NONE);

        // Directed rows: reset state, zero dwell and a dwell of 1000, every mode, restarts
        dir_rows = '{
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(0, 0, 0, 0, 0, 0, 1'b0)},
            '{ROW_TICK, 1'b1, '0, 1'b1, duties_of(0, 0, 0, 0, 0, 0, 1'b0)},
            '{ROW_CFG, REG_DWELL_MS, 10'd0, 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b1, duties_of(0, 0, 0, 0, 0, 0, 1'b0)},
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(1, 0, 0, 0, 0, 1, 1'b0)},
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(2, 0, 0, 0, 0, 2, 1'b0)},
            '{ROW_CFG, REG_PATTERN_MODE, {7'h7F, MODE_CHASE}, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(255, 0, 0, 0, 0, 2, 1'b0)},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_RSV5), 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(255, 0, 0, 0, 0, 2, 1'b0)},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_RSV6), 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b1, duties_of(255, 0, 0, 0, 0, 2, 1'b0)},
            '{ROW_CFG, REG_PATTERN_MODE, {7'h2A, MODE_RSV7}, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b1, duties_of(255, 0, 0, 0, 0, 2, 1'b0)},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_SIREN), 1'b0, '0},
            '{ROW_CFG, REG_DWELL_MS, 10'd1000, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b0, '0},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_WHITE), 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b0, '0},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_PULSE), 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b0, '0},
            '{ROW_CFG, REG_DWELL_MS, 10'd1, 1'b0, '0},
            '{ROW_CFG, REG_PATTERN_MODE, 10'(MODE_FADE), 1'b0, '0},
            '{ROW_TICK, 1'b1, '0, 1'b0, '0},
            '{ROW_TICK, 1'b0, '0, 1'b0, '0}
        };

        mode_q    = MODE_FADE;
        dwell_q   = 10'd10;
        cur_seg   = 0;
        cur_level = 0;
        cur_hold  = 0;
        cur_duty  = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].arg, dir_rows[k].data);
            else
                offer_tick(dir_rows[k].arg, dir_rows[k].has_gold, dir_rows[k].gold);

        // Fade run over the top of the first ramp into the falling one,
        // with one long result hold-off
        in_lazy  = 1'b1;
        out_lazy = 1'b1;
        write_reg(REG_DWELL_MS, 10'd1);
        write_reg(REG_PATTERN_MODE, 10'(MODE_FADE));
        hold_off_req = 1'b1;
        offer_tick(1'b1, 1'b0, '0);
        repeat (FADE_TICKS) offer_tick(1'b0, 1'b0, '0);

        // Chase starts at its last segment; then shrink dwell mid-wait
        in_lazy  = 1'b0;
        out_lazy = 1'b0;
        write_reg(REG_PATTERN_MODE, 10'(MODE_CHASE));
        write_reg(REG_DWELL_MS, 10'd3);
        repeat (110) offer_tick(1'b0, 1'b0, '0);
        write_reg(REG_DWELL_MS, 10'd1);
        in_lazy = 1'b1;
        repeat (205) offer_tick(1'b0, 1'b0, '0);

        // Siren: cross the first fixed wait
        out_lazy = 1'b1;
        write_reg(REG_PATTERN_MODE, 10'(MODE_SIREN));
        write_reg(REG_DWELL_MS, 10'($urandom_range(0, 1000)));
        offer_tick(1'b1, 1'b0, '0);
        repeat (209) offer_tick(1'b0, 1'b0, '0);

        // Short phases with random settings and occasional restarts
        for (ph = 0; ph < 6; ph++)
        begin
            in_lazy  = ($urandom_range(0, 3) != 0);
            out_lazy = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            mode_pick = (r < 85) ? MODE_W'($urandom_range(0, 4)) : MODE_W'($urandom_range(5, 7));
            write_reg(REG_PATTERN_MODE, {7'($urandom), mode_pick});
            r = $urandom_range(0, 99);
            if (r < 55)
                dw_pick = DWELL_W'($urandom_range(1, 3));
            else if (r < 85)
                dw_pick = DWELL_W'($urandom_range(4, 40));
            else if (r < 92)
                dw_pick = '0;
            else
                dw_pick = DWELL_W'($urandom_range(41, 1000));
            write_reg(REG_DWELL_MS, dw_pick);
            n = $urandom_range(8, 20);
            repeat (n) offer_tick($urandom_range(0, 9) == 0, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (!any_fail)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
